/* rtl/rgb_to_hsv_converter_core_macros.svh */
// ----------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication
`define RHSV_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication
`define RHSV_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/rhsv_pkg.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Sector codes and fixed constants of the hue computation.
// ----------------------------------------------------------------------------
package rhsv_pkg;

    // Channel that holds the maximum, ties go to the earlier channel
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Hue sectors per turn and the sector offsets of green and blue
    localparam int SECTORS      = 6;
    localparam int GREEN_OFFSET = 2;
    localparam int BLUE_OFFSET  = 4;

endpackage

/* rtl/rgb_to_hsv_converter_core.sv */
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Streams RGBA in and HSVA out, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while no result is stalled. Three
// stages find the maximum and minimum, form the channel difference and
// build the hue numerator and saturation dividend; the rest of the depth
// is set by the two restoring dividers, which resolve one quotient bit per
// stage until their quotients are full and run side by side. A low m_tready
// with a result waiting freezes the whole pipeline, and s_tready follows it
// in the same cycle.
`include "rgb_to_hsv_converter_core_macros.svh"

module rgb_to_hsv_converter_core
    import rhsv_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // red, green, blue, alpha (lowest bits first)
    input  logic [((4*CHANNEL_BITS+7)/8)*8-1:0]                s_tdata,
    input  logic                                               s_tvalid,
    output logic                                               s_tready,
    // hue, saturation, value, alpha (lowest bits first)
    output logic [((HUE_BITS+3*CHANNEL_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                               m_tvalid,
    input  logic                                               m_tready
);

    localparam int CB    = CHANNEL_BITS;
    localparam int NW    = CHANNEL_BITS + 3;  // hue numerator and divisor
    localparam int SW    = CHANNEL_BITS + 4;  // signed numerator before wrap
    localparam int NSTEP = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    logic en;

    // Stall everything while a result waits
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: maximum, minimum and sector
    logic [CB-1:0] red_in, green_in, blue_in, alpha_in;
    logic [CB-1:0] mx1_next, mn1_next;
    sector_t       sel1_next;
    logic [CB-1:0] red1_reg, green1_reg, blue1_reg, alpha1_reg, mx1_reg, mn1_reg;
    sector_t       sel1_reg;
    logic          v1_reg, v1_next;

    assign red_in   = s_tdata[0*CB +: CB];
    assign green_in = s_tdata[1*CB +: CB];
    assign blue_in  = s_tdata[2*CB +: CB];
    assign alpha_in = s_tdata[3*CB +: CB];
    assign v1_next  = s_tvalid;

    always_comb begin
        if (red_in >= green_in && red_in >= blue_in) begin
            sel1_next = SECT_RED;
            mx1_next  = red_in;
        end else if (green_in >= blue_in) begin
            sel1_next = SECT_GREEN;
            mx1_next  = green_in;
        end else begin
            sel1_next = SECT_BLUE;
            mx1_next  = blue_in;
        end
        mn1_next = (red_in <= green_in) ? red_in : green_in;
        mn1_next = (mn1_next <= blue_in) ? mn1_next : blue_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red1_reg   <= red_in;
            green1_reg <= green_in;
            blue1_reg  <= blue_in;
            alpha1_reg <= alpha_in;
            mx1_reg    <= mx1_next;
            mn1_reg    <= mn1_next;
            sel1_reg   <= sel1_next;
        end
    end

    // Stage 2: delta and the channel difference of the sector
    logic [CB-1:0] delta2_next;
    logic [CB:0]   diff2_next;
    logic [CB-1:0] delta2_reg, mx2_reg, alpha2_reg;
    logic [CB:0]   diff2_reg;
    sector_t       sel2_reg;
    logic          v2_reg;

    always_comb begin
        delta2_next = mx1_reg - mn1_reg;
        case (sel1_reg)
            SECT_RED:   diff2_next = {1'b0, green1_reg} - {1'b0, blue1_reg};
            SECT_GREEN: diff2_next = {1'b0, blue1_reg} - {1'b0, red1_reg};
            SECT_BLUE:  diff2_next = {1'b0, red1_reg} - {1'b0, green1_reg};
            default:    diff2_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta2_reg <= delta2_next;
            diff2_reg  <= diff2_next;
            mx2_reg    <= mx1_reg;
            alpha2_reg <= alpha1_reg;
            sel2_reg   <= sel1_reg;
        end
    end

    // Stage 3: wrapped hue numerator, six-delta divisor, saturation dividend
    logic [SW-1:0]   off3, num_raw3, num_wrap3;
    logic [NW-1:0]   num3_next, dvs3_next;
    logic [2*CB-1:0] satn3_next;
    logic [NW-1:0]   num3_reg, dvs3_reg;
    logic [2*CB-1:0] satn3_reg;
    logic [CB-1:0]   mx3_reg, alpha3_reg;
    logic            grey3_reg, grey3_next;
    logic            v3_reg;

    always_comb begin
        case (sel2_reg)
            SECT_RED:   off3 = '0;
            SECT_GREEN: off3 = SW'(GREEN_OFFSET) * SW'(delta2_reg);
            SECT_BLUE:  off3 = SW'(BLUE_OFFSET) * SW'(delta2_reg);
            default:    off3 = '0;
        endcase
        dvs3_next  = NW'(SECTORS) * NW'(delta2_reg);
        num_raw3   = off3 + {{3{diff2_reg[CB]}}, diff2_reg};
        num_wrap3  = num_raw3[SW-1] ? (num_raw3 + SW'(dvs3_next)) : num_raw3;
        num3_next  = num_wrap3[NW-1:0];
        satn3_next = {delta2_reg, {CB{1'b0}}} - {{CB{1'b0}}, delta2_reg};
        grey3_next = (delta2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num3_reg   <= num3_next;
            dvs3_reg   <= dvs3_next;
            satn3_reg  <= satn3_next;
            mx3_reg    <= mx2_reg;
            alpha3_reg <= alpha2_reg;
            grey3_reg  <= grey3_next;
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Hue and saturation dividers
    logic [HUE_BITS-1:0] hue_quo;
    logic [CB-1:0]       sat_quo;

    rhsv_divider #(
        .QBITS  (HUE_BITS),
        .DBITS  (NW),
        .STAGES (NSTEP)
    ) u_hue_div (
        .aclk    (aclk),
        .en      (en),
        .rem_in  (num3_reg),
        .low_in  ({HUE_BITS{1'b0}}),
        .div_in  (dvs3_reg),
        .quo_out (hue_quo)
    );

    rhsv_divider #(
        .QBITS  (CB),
        .DBITS  (CB),
        .STAGES (NSTEP)
    ) u_sat_div (
        .aclk    (aclk),
        .en      (en),
        .rem_in  (satn3_reg[2*CB-1:CB]),
        .low_in  (satn3_reg[CB-1:0]),
        .div_in  (mx3_reg),
        .quo_out (sat_quo)
    );

    // Delay value, alpha, grey flag and valid alongside the dividers
    logic [CB-1:0] mx_line_reg    [NSTEP];
    logic [CB-1:0] alpha_line_reg [NSTEP];
    logic          grey_line_reg  [NSTEP];
    logic          vld_line_reg   [NSTEP];

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_line_reg[0]    <= mx3_reg;
            alpha_line_reg[0] <= alpha3_reg;
            grey_line_reg[0]  <= grey3_reg;
            for (int k = 1; k < NSTEP; k++) begin
                mx_line_reg[k]    <= mx_line_reg[k-1];
                alpha_line_reg[k] <= alpha_line_reg[k-1];
                grey_line_reg[k]  <= grey_line_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTEP; k++) begin
                vld_line_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_line_reg[0] <= v3_reg;
            for (int k = 1; k < NSTEP; k++) begin
                vld_line_reg[k] <= vld_line_reg[k-1];
            end
        end
    end

    // Pack the result, zero hue and saturation for grey pixels
    logic grey_out;

    assign grey_out = grey_line_reg[NSTEP-1];
    assign m_tvalid = vld_line_reg[NSTEP-1];

    always_comb begin
        m_tdata                              = '0;
        m_tdata[0 +: HUE_BITS]               = grey_out ? '0 : hue_quo;
        m_tdata[HUE_BITS +: CB]              = grey_out ? '0 : sat_quo;
        m_tdata[HUE_BITS + CB +: CB]         = mx_line_reg[NSTEP-1];
        m_tdata[HUE_BITS + 2*CB +: CB]       = alpha_line_reg[NSTEP-1];
    end

    // Divider operands must start with the remainder below the divisor
    `RHSV_ASSERT_IMP(a_hue_num_below_div, v3_reg && !grey3_reg, num3_reg < dvs3_reg)
    `RHSV_ASSERT_IMP(a_sat_top_below_max, v3_reg && !grey3_reg, satn3_reg[2*CB-1:CB] < mx3_reg)
    // A colored pixel always has a nonzero value
    `RHSV_ASSERT_IMP(a_color_has_value, m_tvalid && !grey_out, mx_line_reg[NSTEP-1] != '0)
    // A stall freezes the valid bits inside the pipeline
    `RHSV_ASSERT_NXT(a_stall_holds, !en, $stable(v3_reg) && $stable(vld_line_reg[0]))

endmodule

/* rtl/rhsv_divider.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage up to QBITS, then hold. The start
// remainder must be below the divisor; the low dividend bits shift in from the top of the quotient word.
// ----------------------------------------------------------------------------
module rhsv_divider
    import rhsv_pkg::*;
#(
    parameter int QBITS  = 16,
    parameter int DBITS  = 11,
    parameter int STAGES = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DBITS-1:0] rem_in,
    input  logic [QBITS-1:0] low_in,
    input  logic [DBITS-1:0] div_in,
    output logic [QBITS-1:0] quo_out
);

    logic [DBITS-1:0] rem_reg  [STAGES];
    logic [QBITS-1:0] word_reg [STAGES];
    logic [DBITS-1:0] div_reg  [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            logic [DBITS-1:0] rem_prev;
            logic [QBITS-1:0] word_prev;
            logic [DBITS-1:0] div_prev;
            logic [DBITS-1:0] rem_next;
            logic [QBITS-1:0] word_next;

            // Pick the stage input
            if (k == 0) begin : g_first
                assign rem_prev  = rem_in;
                assign word_prev = low_in;
                assign div_prev  = div_in;
            end else begin : g_rest
                assign rem_prev  = rem_reg[k-1];
                assign word_prev = word_reg[k-1];
                assign div_prev  = div_reg[k-1];
            end

            // Shift in the next dividend bit, subtract when it fits
            if (k < QBITS) begin : g_step
                logic [DBITS:0] trial;
                logic           ge;

                always_comb begin
                    trial     = {rem_prev, word_prev[QBITS-1]};
                    ge        = (trial >= {1'b0, div_prev});
                    rem_next  = ge ? DBITS'(trial - {1'b0, div_prev}) : trial[DBITS-1:0];
                    word_next = {word_prev[QBITS-2:0], ge};
                end
            end else begin : g_hold
                always_comb begin
                    rem_next  = rem_prev;
                    word_next = word_prev;
                end
            end

            // Advance the stage
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next;
                    word_reg[k] <= word_next;
                    div_reg[k]  <= div_prev;
                end
            end
        end
    endgenerate

    assign quo_out = word_reg[STAGES-1];

endmodule
